// ===== hdl/unf_pkg.sv =====
// Package for the URL path normalizer: word types, scan modes and helper functions.
// Depends on nothing; used by every module of the block except unf_ram.
`default_nettype none
package unf_pkg;

  localparam int MAX_CANON_DEF = 2048;
  localparam int MAX_DEPTH_DEF = 64;
  localparam int PREFIX_KEEP = 13;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_ESCAPE = 3'd1;
  localparam logic [2:0] ST_NUL = 3'd2;
  localparam logic [2:0] ST_ABOVE_ROOT = 3'd3;
  localparam logic [2:0] ST_TOO_DEEP = 3'd4;
  localparam logic [2:0] ST_TOO_LONG = 3'd5;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_HIGH   = 2'd1,
    MODE_LOW    = 2'd2,
    MODE_CUT    = 2'd3
  } mode_t;

  typedef struct packed {
    logic       ch_vld;
    logic [7:0] ch;
    logic       bad;
    logic       fin;
  } ev_t;

  typedef logic [PREFIX_KEEP-1:0][7:0] prefix_t;

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] lower_byte(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // The pattern is left-justified: its first byte sits in the top bits.
  function automatic logic pat_match(input prefix_t pfx, input logic [15:0] len,
                                     input logic [8*PREFIX_KEEP-1:0] pat,
                                     input int plen, input logic exact);
    logic ok;
    ok = exact ? (len == 16'(plen)) : (len >= 16'(plen));
    for (int i = 0; i < PREFIX_KEEP; i++) begin
      if (i < plen && lower_byte(pfx[i]) != pat[8*(PREFIX_KEEP-i)-1 -: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [8*PREFIX_KEEP-1:0] lj(input logic [8*PREFIX_KEEP-1:0] s,
                                                 input int plen);
    return s << (8 * (PREFIX_KEEP - plen));
  endfunction

  function automatic logic is_gated(input prefix_t pfx, input logic [15:0] len);
    logic g;
    g = pat_match(pfx, len, lj("/api/v1", 7), 7, 1'b1)
      | pat_match(pfx, len, lj("/api/v1/", 8), 8, 1'b0)
      | pat_match(pfx, len, lj("/x402", 5), 5, 1'b1)
      | pat_match(pfx, len, lj("/x402/", 6), 6, 1'b0)
      | pat_match(pfx, len, lj("/wallet", 7), 7, 1'b1)
      | pat_match(pfx, len, lj("/wallet.html", 12), 12, 1'b1)
      | pat_match(pfx, len, lj("/", 1), 1, 1'b1)
      | pat_match(pfx, len, lj("/api/stats", 10), 10, 1'b1)
      | pat_match(pfx, len, lj("/metrics", 8), 8, 1'b1);
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/url_path_normalize_and_gate.sv =====
// Top level of the URL path normalizer and sensitivity gate.
// Depends on unf_pkg, unf_front, unf_queue and unf_back.
//
// Channel  Direction  Handshake       Word
// in_      input      push/full       path_byte, has_byte, last
// out_     output     empty/pop       status, sensitive, canonical_length, segment_count
//
// One byte per cycle while full is low; a result reaches the ports through the event
// queue and then the result register, once its last byte is accepted.
// The rate is set by the back end, which handles one event word per cycle unless a last word waits.
// Reset is synchronous; no clearing pass is needed.
// A full result register stalls the back end only on a last word; the queue absorbs the rest.
`default_nettype none
module url_path_normalize_and_gate #(
  parameter int MAX_CANON = unf_pkg::MAX_CANON_DEF,
  parameter int MAX_DEPTH = unf_pkg::MAX_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_path_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       out_status,
  output logic             out_sensitive,
  output logic [11:0]      out_canonical_length,
  output logic [6:0]       out_segment_count
);
  logic         acc, fe_vld, q_vld, q_take, out_vld;
  unf_pkg::ev_t fe_ev, q_ev;

  assign acc = push && !full;
  assign empty = !out_vld;

  unf_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .path_byte(in_path_byte),
    .has_byte(in_has_byte), .last(in_last), .ev_vld(fe_vld), .ev(fe_ev)
  );

  unf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr(fe_vld), .wdata(fe_ev), .full(full),
    .rd(q_take), .vld(q_vld), .rdata(q_ev)
  );

  unf_back #(.MAX_CANON(MAX_CANON), .MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .ev_vld(q_vld), .ev(q_ev), .ev_take(q_take),
    .out_pop(pop), .out_vld(out_vld), .out_status(out_status),
    .out_sensitive(out_sensitive), .out_canonical_length(out_canonical_length),
    .out_segment_count(out_segment_count)
  );

`ifndef SYNTHESIS
  a_err_sens: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != unf_pkg::ST_OK) |-> out_sensitive)
    else $error("Failed path not marked sensitive.");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != unf_pkg::ST_OK) |->
      (out_canonical_length == 12'd0 && out_segment_count == 7'd0))
    else $error("Failed path reports length or segments.");
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == unf_pkg::ST_OK) |-> (out_canonical_length != 12'd0))
    else $error("Good path with zero length.");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_status)))
    else $error("Waiting result changed.");
`endif
endmodule
`default_nettype wire

// ===== hdl/unf_ram.sv =====
// Generic single-port-write RAM with registered read.
// Depends on nothing.
`default_nettype none
module unf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/unf_front.sv =====
// Front end: cuts at query or fragment, decodes percent escapes, emits event words.
// Depends on unf_pkg.
`default_nettype none
module unf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire logic [7:0]    path_byte,
  input  wire logic          has_byte,
  input  wire logic          last,
  output logic               ev_vld,
  output unf_pkg::ev_t       ev
);
  unf_pkg::mode_t mode_r, mode_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic [4:0] nib;
  logic       is_cut;

  assign nib = unf_pkg::hex_nibble(path_byte);
  assign is_cut = (path_byte == 8'h3F) || (path_byte == 8'h23);

  always_comb begin
    mode_nxt = mode_r;
    hi_nxt = hi_r;
    if (acc) begin
      if (has_byte && mode_r != unf_pkg::MODE_CUT) begin
        if (is_cut) begin
          mode_nxt = unf_pkg::MODE_CUT;
        end else if (mode_r == unf_pkg::MODE_NORMAL) begin
          if (path_byte == 8'h25) mode_nxt = unf_pkg::MODE_HIGH;
        end else if (nib[4]) begin
          mode_nxt = unf_pkg::MODE_CUT;
        end else if (mode_r == unf_pkg::MODE_HIGH) begin
          hi_nxt = nib[3:0];
          mode_nxt = unf_pkg::MODE_LOW;
        end else begin
          mode_nxt = unf_pkg::MODE_NORMAL;
        end
      end
      if (last) mode_nxt = unf_pkg::MODE_NORMAL;
    end
  end

  always_comb begin
    ev = '0;
    ev.fin = last;
    if (has_byte && mode_r != unf_pkg::MODE_CUT) begin
      if (is_cut) begin
        ev.bad = (mode_r != unf_pkg::MODE_NORMAL);
      end else if (mode_r == unf_pkg::MODE_NORMAL) begin
        if (path_byte != 8'h25) begin
          ev.ch_vld = 1'b1;
          ev.ch = path_byte;
        end
      end else if (nib[4]) begin
        ev.bad = 1'b1;
      end else if (mode_r == unf_pkg::MODE_LOW) begin
        ev.ch_vld = 1'b1;
        ev.ch = {hi_r, nib[3:0]};
      end
    end
    if (last && !(has_byte && !is_cut && mode_r == unf_pkg::MODE_LOW && !nib[4])
        && (mode_r == unf_pkg::MODE_LOW || mode_r == unf_pkg::MODE_HIGH ||
            (has_byte && mode_r == unf_pkg::MODE_NORMAL && path_byte == 8'h25))) begin
      ev.bad = 1'b1;
    end
    ev_vld = acc && (ev.ch_vld || ev.bad || ev.fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= unf_pkg::MODE_NORMAL;
    end else begin
      mode_r <= mode_nxt;
    end
    hi_r <= hi_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/unf_queue.sv =====
// Short queue of event words between the front end and the back end.
// Depends on unf_pkg.
`default_nettype none
module unf_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr,
  input  wire unf_pkg::ev_t wdata,
  output logic              full,
  input  wire logic         rd,
  output logic              vld,
  output unf_pkg::ev_t      rdata
);
  localparam int AW = $clog2(unf_pkg::QUEUE_DEPTH);
  unf_pkg::ev_t mem_r [unf_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full = (cnt_r == (AW+1)'(unf_pkg::QUEUE_DEPTH));
  assign vld = (cnt_r != '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem_r[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

// ===== hdl/unf_back.sv =====
// Back end: segment stack, dot resolution, length and error tracking, verdict register.
// Depends on unf_pkg and unf_ram.
`default_nettype none
module unf_back #(
  parameter int MAX_CANON = unf_pkg::MAX_CANON_DEF,
  parameter int MAX_DEPTH = unf_pkg::MAX_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         ev_vld,
  input  wire unf_pkg::ev_t ev,
  output logic              ev_take,
  input  wire logic         out_pop,
  output logic              out_vld,
  output logic [2:0]        out_status,
  output logic              out_sensitive,
  output logic [11:0]       out_canonical_length,
  output logic [6:0]        out_segment_count
);
  localparam int LW = $clog2(MAX_CANON + 1);
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(MAX_DEPTH);

  logic [LW-1:0] len_r, len_nxt, cs_r, cs_nxt, top_r, rdata;
  logic [DW-1:0] dep_r, dep_nxt;
  logic [1:0]    dot_r, dot_nxt;
  logic          ins_r, ins_nxt, pend_r;
  logic [2:0]    err_r, err_nxt;
  unf_pkg::prefix_t pfx_r, pfx_nxt;
  logic          push, pop, do_end;
  logic [AW-1:0] raddr;
  logic [DW-1:0] dep_m1;

  assign ev_take = ev_vld && (!ev.fin || !out_vld || out_pop);

  unf_ram #(.WIDTH(LW), .DEPTH(MAX_DEPTH)) u_stack (
    .clk(clk), .we(push), .waddr(dep_r[AW-1:0]), .wdata(cs_nxt),
    .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    len_nxt = len_r; cs_nxt = cs_r; dep_nxt = dep_r; dot_nxt = dot_r;
    ins_nxt = ins_r; err_nxt = err_r; pfx_nxt = pfx_r;
    push = 1'b0; pop = 1'b0; do_end = 1'b0;
    dep_m1 = dep_r - 1'b1;
    raddr = AW'(dep_m1 - 1'b1);
    if (ev_take) begin
      if (ev.ch_vld) begin
        if (ev.ch == 8'h00) begin
          if (err_nxt == unf_pkg::ST_OK || unf_pkg::ST_NUL < err_nxt) err_nxt = unf_pkg::ST_NUL;
        end else if (err_nxt != unf_pkg::ST_OK) begin
          err_nxt = err_nxt;
        end else if (ev.ch == 8'h2F) begin
          do_end = ins_nxt;
        end else begin
          if (!ins_nxt) begin
            ins_nxt = 1'b1;
            dot_nxt = 2'd0;
            cs_nxt = len_nxt;
            if (dep_nxt != '0) begin
              if (len_nxt >= LW'(MAX_CANON)) begin
                err_nxt = unf_pkg::ST_TOO_LONG;
              end else begin
                if (len_nxt < LW'(unf_pkg::PREFIX_KEEP)) pfx_nxt[len_nxt[3:0]] = 8'h2F;
                len_nxt = len_nxt + 1'b1;
              end
            end
          end
          if (err_nxt == unf_pkg::ST_OK) begin
            dot_nxt = (ev.ch == 8'h2E && dot_nxt < 2'd2) ? dot_nxt + 1'b1 : 2'd3;
            if (len_nxt >= LW'(MAX_CANON)) begin
              err_nxt = unf_pkg::ST_TOO_LONG;
            end else begin
              if (len_nxt < LW'(unf_pkg::PREFIX_KEEP)) pfx_nxt[len_nxt[3:0]] = ev.ch;
              len_nxt = len_nxt + 1'b1;
            end
          end
        end
      end
      if (ev.bad) err_nxt = unf_pkg::ST_BAD_ESCAPE;
      if (do_end || (ev.fin && err_nxt == unf_pkg::ST_OK && ins_nxt)) begin
        ins_nxt = 1'b0;
        if (dot_nxt == 2'd1) begin
          len_nxt = cs_nxt;
        end else if (dot_nxt == 2'd2) begin
          len_nxt = cs_nxt;
          if (dep_nxt == '0) begin
            if (err_nxt == unf_pkg::ST_OK || unf_pkg::ST_ABOVE_ROOT < err_nxt)
              err_nxt = unf_pkg::ST_ABOVE_ROOT;
          end else begin
            pop = 1'b1;
            dep_nxt = dep_m1;
            len_nxt = top_r;
          end
        end else if (dep_nxt >= DW'(MAX_DEPTH)) begin
          if (err_nxt == unf_pkg::ST_OK) err_nxt = unf_pkg::ST_TOO_DEEP;
        end else begin
          push = 1'b1;
          dep_nxt = dep_nxt + 1'b1;
        end
      end
    end
    pfx_nxt[0] = 8'h2F;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LW'(1); cs_r <= '0; dep_r <= '0; dot_r <= '0; ins_r <= 1'b0;
      err_r <= unf_pkg::ST_OK; pend_r <= 1'b0; out_vld <= 1'b0;
    end else begin
      pend_r <= pop && (dep_m1 != '0);
      if (ev_take && ev.fin) begin
        out_vld <= 1'b1;
        len_r <= LW'(1); cs_r <= '0; dep_r <= '0; dot_r <= '0; ins_r <= 1'b0;
        err_r <= unf_pkg::ST_OK;
      end else begin
        if (out_pop && out_vld) out_vld <= 1'b0;
        len_r <= len_nxt; cs_r <= cs_nxt; dep_r <= dep_nxt; dot_r <= dot_nxt;
        ins_r <= ins_nxt; err_r <= err_nxt;
      end
    end
    pfx_r <= pfx_nxt;
    if (push) top_r <= cs_nxt;
    else if (pend_r) top_r <= rdata;
    if (ev_take && ev.fin) begin
      out_status <= err_nxt;
      out_sensitive <= (err_nxt != unf_pkg::ST_OK) || unf_pkg::is_gated(pfx_nxt, 16'(len_nxt));
      out_canonical_length <= (err_nxt != unf_pkg::ST_OK) ? 12'd0 : 12'(len_nxt);
      out_segment_count <= (err_nxt != unf_pkg::ST_OK) ? 7'd0 : 7'(dep_nxt);
    end
  end
endmodule
`default_nettype wire
